### rtl/pts_pkg.sv
// ----------------------------------------------------------------------------
// Periodic task scheduler package
// Shared constants, command and status codes, the slot entry layout and the due check.
// ----------------------------------------------------------------------------
package pts_pkg;

  localparam int TASKS  = 16;
  localparam int SLOT_W = $clog2(TASKS);
  localparam int CNT_W  = $clog2(TASKS + 1);

  localparam logic [7:0] PRIO_NONE = 8'd255;

  localparam logic [3:0] CMD_REGISTER   = 4'd0;
  localparam logic [3:0] CMD_UNREGISTER = 4'd1;
  localparam logic [3:0] CMD_START      = 4'd2;
  localparam logic [3:0] CMD_STOP       = 4'd3;
  localparam logic [3:0] CMD_SUSPEND    = 4'd4;
  localparam logic [3:0] CMD_RESUME     = 4'd5;
  localparam logic [3:0] CMD_SET_PERIOD = 4'd6;
  localparam logic [3:0] CMD_SET_PRIO   = 4'd7;
  localparam logic [3:0] CMD_DISPATCH   = 4'd8;
  localparam logic [3:0] CMD_COMPLETE   = 4'd9;
  localparam logic [3:0] CMD_READ       = 4'd10;
  localparam logic [3:0] CMD_CLR_STATS  = 4'd11;
  localparam logic [3:0] CMD_SUSP_ALL   = 4'd12;
  localparam logic [3:0] CMD_RES_ALL    = 4'd13;
  localparam logic [3:0] CMD_PENDING    = 4'd14;
  localparam logic [3:0] CMD_RESERVED   = 4'd15;

  localparam logic [2:0] STS_OK        = 3'd0;
  localparam logic [2:0] STS_FULL      = 3'd1;
  localparam logic [2:0] STS_BAD_PARAM = 3'd2;
  localparam logic [2:0] STS_NOT_FOUND = 3'd3;
  localparam logic [2:0] STS_BAD_STATE = 3'd4;

  localparam logic [1:0] TS_STOPPED   = 2'd0;
  localparam logic [1:0] TS_READY     = 2'd1;
  localparam logic [1:0] TS_RUNNING   = 2'd2;
  localparam logic [1:0] TS_SUSPENDED = 2'd3;

  typedef struct packed {
    logic [7:0]  tag;
    logic [31:0] period;
    logic [7:0]  priority_num;
    logic [31:0] last_run;
    logic [31:0] max_exec;
    logic [31:0] max_jitter;
  } slot_entry_t;

  function automatic logic is_due(input logic [31:0] now_t, input logic [31:0] last_run,
                                  input logic [31:0] period);
    logic [31:0] elapsed;
    elapsed = now_t - last_run;
    return elapsed >= period;
  endfunction

endpackage

### rtl/pts_slot_ram.sv
// ----------------------------------------------------------------------------
// Slot table memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module pts_slot_ram (
  input  logic                       clk,
  input  logic                       we,
  input  logic [pts_pkg::SLOT_W-1:0] waddr,
  input  pts_pkg::slot_entry_t       wdata,
  input  logic [pts_pkg::SLOT_W-1:0] raddr,
  output pts_pkg::slot_entry_t       rdata
);
  import pts_pkg::*;

  slot_entry_t mem [TASKS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/periodic_priority_task_scheduler.sv
// ----------------------------------------------------------------------------
// Periodic priority task scheduler
// Command-driven table of periodic tasks with fixed-priority dispatch.
// ----------------------------------------------------------------------------
// Every command passes from the start transfer to the done strobe through a
// scan that reads one slot of the table memory per cycle, then the read,
// calculate and execute states finish the command on the chosen slot.
// A new command is taken only when idle; busy is high from acceptance until done.
// The result is shown for one cycle and cannot be stalled by the receiver.
// Synchronous reset clears all slot flags, the task count and the next id; no clearing pass.
module periodic_priority_task_scheduler (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [3:0]  command,
  input  logic [31:0] now,
  input  logic [7:0]  task_id,
  input  logic [31:0] period,
  input  logic [7:0]  priority_req,
  output logic        done,
  output logic [2:0]  status,
  output logic [7:0]  result_id,
  output logic        found,
  output logic [31:0] info_period,
  output logic [7:0]  info_priority,
  output logic [31:0] info_last_run,
  output logic [31:0] info_max_exec,
  output logic [31:0] info_max_jitter,
  output logic [1:0]  info_state,
  output logic [pts_pkg::CNT_W-1:0] task_count,
  output logic [pts_pkg::CNT_W-1:0] affected_count,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import pts_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;
  localparam logic [2:0] S_READ = 3'd2;
  localparam logic [2:0] S_CALC = 3'd3;
  localparam logic [2:0] S_EXEC = 3'd4;

  logic [2:0]        fsm;
  logic [7:0]        priority_limit;
  logic [TASKS-1:0]  slot_used;
  logic [1:0]        slot_state [TASKS];
  logic [7:0]        next_id;
  logic [CNT_W-1:0]  used_count;
  logic              task_busy;
  logic [SLOT_W-1:0] running_slot;

  logic [3:0]        cmd_q;
  logic [31:0]       now_q;
  logic [7:0]        id_q;
  logic [31:0]       per_q;
  logic [7:0]        pri_q;

  logic [SLOT_W:0]   scan_cnt;
  logic              ev_vld;
  logic [SLOT_W-1:0] ev_idx;
  logic              hit;
  logic [SLOT_W-1:0] sel;
  logic [7:0]        best;
  logic [CNT_W-1:0]  affected;

  slot_entry_t       ram_rdata;
  slot_entry_t       ram_wdata;
  logic              ram_we;
  logic [SLOT_W-1:0] ram_waddr;
  logic [SLOT_W-1:0] ram_raddr;

  slot_entry_t       ent_q;
  logic [31:0]       sched_q;
  logic [31:0]       exec_q;

  logic              cfg_write;
  logic              ev_used;
  logic [1:0]        ev_state;
  logic              ev_due;
  logic [31:0]       jitter;
  logic              param_bad;
  logic [1:0]        sel_state;

  pts_slot_ram u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign busy      = (fsm != S_IDLE);
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && !paddr[2];
  assign prdata    = paddr[2] ? 32'd0 : {24'd0, priority_limit};
  assign task_count = used_count;

  assign ev_used  = slot_used[ev_idx];
  assign ev_state = slot_state[ev_idx];
  assign ev_due   = ev_used && (ev_state == TS_READY) &&
                    is_due(now_q, ram_rdata.last_run, ram_rdata.period);
  assign jitter   = (now_q > sched_q) ? (now_q - sched_q) : (sched_q - now_q);
  assign param_bad = ((cmd_q == CMD_SET_PERIOD) && (per_q == 32'd0)) ||
                     ((cmd_q == CMD_SET_PRIO) && (pri_q > priority_limit));
  assign sel_state = slot_state[sel];

  always_comb begin
    ram_raddr = (fsm == S_SCAN) ? scan_cnt[SLOT_W-1:0] : sel;
  end

  // Memory write: resume-all stamps during the scan, the rest in execute.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = sel;
    ram_wdata = ent_q;
    if (fsm == S_SCAN) begin
      ram_waddr = ev_idx;
      ram_wdata = ram_rdata;
      ram_wdata.last_run = now_q;
      ram_we = ev_vld && (cmd_q == CMD_RES_ALL) && ev_used && (ev_state == TS_SUSPENDED);
    end else if (fsm == S_EXEC) begin
      unique case (cmd_q)
        CMD_REGISTER: begin
          ram_we = hit;
          ram_wdata.tag          = next_id;
          ram_wdata.period       = per_q;
          ram_wdata.priority_num = pri_q;
          ram_wdata.last_run     = now_q;
          ram_wdata.max_exec     = 32'd0;
          ram_wdata.max_jitter   = 32'd0;
        end
        CMD_DISPATCH: begin
          ram_we = hit && !task_busy;
          ram_wdata.last_run = now_q;
          if (jitter > ent_q.max_jitter) begin
            ram_wdata.max_jitter = jitter;
          end
        end
        CMD_COMPLETE: begin
          ram_we = task_busy;
          if (exec_q > ent_q.max_exec) begin
            ram_wdata.max_exec = exec_q;
          end
        end
        CMD_START: begin
          ram_we = hit && !param_bad;
          ram_wdata.last_run = now_q;
        end
        CMD_RESUME: begin
          ram_we = hit && (sel_state == TS_SUSPENDED);
          ram_wdata.last_run = now_q;
        end
        CMD_SET_PERIOD: begin
          ram_we = hit && !param_bad;
          ram_wdata.period   = per_q;
          ram_wdata.last_run = now_q;
        end
        CMD_SET_PRIO: begin
          ram_we = hit && !param_bad;
          ram_wdata.priority_num = pri_q;
        end
        CMD_CLR_STATS: begin
          ram_we = hit;
          ram_wdata.max_exec   = 32'd0;
          ram_wdata.max_jitter = 32'd0;
        end
        default: begin
          ram_we = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fsm            <= S_IDLE;
      priority_limit <= PRIO_NONE;
      slot_used      <= '0;
      for (int i = 0; i < TASKS; i++) begin
        slot_state[i] <= TS_STOPPED;
      end
      next_id        <= 8'd0;
      used_count     <= '0;
      task_busy      <= 1'b0;
      running_slot   <= '0;
      done           <= 1'b0;
      ev_vld         <= 1'b0;
    end else begin
      done <= 1'b0;
      if (cfg_write) begin
        priority_limit <= pwdata[7:0];
      end
      unique case (fsm)
        S_IDLE: begin
          if (start) begin
            cmd_q    <= command;
            now_q    <= now;
            id_q     <= task_id;
            per_q    <= period;
            pri_q    <= priority_req;
            scan_cnt <= '0;
            ev_vld   <= 1'b0;
            hit      <= 1'b0;
            sel      <= '0;
            best     <= PRIO_NONE;
            affected <= '0;
            fsm      <= S_SCAN;
          end
        end
        S_SCAN: begin
          ev_vld <= (scan_cnt < (SLOT_W + 1)'(TASKS));
          ev_idx <= scan_cnt[SLOT_W-1:0];
          if (scan_cnt < (SLOT_W + 1)'(TASKS)) begin
            scan_cnt <= scan_cnt + 1'b1;
          end
          if (ev_vld) begin
            unique case (cmd_q)
              CMD_REGISTER: begin
                if (!ev_used && !hit) begin
                  hit <= 1'b1;
                  sel <= ev_idx;
                end
              end
              CMD_DISPATCH: begin
                if (ev_due && (ram_rdata.priority_num < best)) begin
                  hit  <= 1'b1;
                  sel  <= ev_idx;
                  best <= ram_rdata.priority_num;
                end
              end
              CMD_PENDING: begin
                if (ev_due) begin
                  hit <= 1'b1;
                end
              end
              CMD_SUSP_ALL: begin
                if (ev_used && (ev_state == TS_READY || ev_state == TS_RUNNING)) begin
                  slot_state[ev_idx] <= TS_SUSPENDED;
                  affected <= affected + 1'b1;
                end
              end
              CMD_RES_ALL: begin
                if (ev_used && (ev_state == TS_SUSPENDED)) begin
                  slot_state[ev_idx] <= TS_READY;
                  affected <= affected + 1'b1;
                end
              end
              default: begin
                if (ev_used && (ram_rdata.tag == id_q) && !hit) begin
                  hit <= 1'b1;
                  sel <= ev_idx;
                end
              end
            endcase
            if (ev_idx == SLOT_W'(TASKS - 1)) begin
              fsm <= S_READ;
              if (cmd_q == CMD_COMPLETE) begin
                sel <= running_slot;
              end
            end
          end
        end
        S_READ: begin
          fsm <= S_CALC;
        end
        S_CALC: begin
          ent_q   <= ram_rdata;
          sched_q <= ram_rdata.last_run + ram_rdata.period;
          exec_q  <= now_q - ram_rdata.last_run;
          fsm     <= S_EXEC;
        end
        S_EXEC: begin
          fsm             <= S_IDLE;
          done            <= 1'b1;
          status          <= STS_OK;
          result_id       <= 8'd0;
          found           <= 1'b0;
          info_period     <= 32'd0;
          info_priority   <= 8'd0;
          info_last_run   <= 32'd0;
          info_max_exec   <= 32'd0;
          info_max_jitter <= 32'd0;
          info_state      <= TS_STOPPED;
          affected_count  <= '0;
          unique case (cmd_q)
            CMD_REGISTER: begin
              if (hit) begin
                slot_used[sel]  <= 1'b1;
                slot_state[sel] <= TS_READY;
                result_id       <= next_id;
                next_id         <= next_id + 8'd1;
                used_count      <= used_count + 1'b1;
              end else begin
                status <= STS_FULL;
              end
            end
            CMD_DISPATCH: begin
              if (task_busy) begin
                status <= STS_BAD_STATE;
              end else if (hit) begin
                slot_state[sel] <= TS_RUNNING;
                task_busy       <= 1'b1;
                running_slot    <= sel;
                found           <= 1'b1;
                result_id       <= ent_q.tag;
              end
            end
            CMD_COMPLETE: begin
              if (!task_busy) begin
                status <= STS_BAD_STATE;
              end else begin
                if (sel_state == TS_RUNNING) begin
                  slot_state[sel] <= TS_READY;
                end
                task_busy <= 1'b0;
                result_id <= ent_q.tag;
              end
            end
            CMD_SUSP_ALL, CMD_RES_ALL: begin
              affected_count <= affected;
            end
            CMD_PENDING: begin
              found <= hit;
            end
            CMD_RESERVED: begin
              status <= STS_BAD_PARAM;
            end
            default: begin
              result_id <= id_q;
              if (param_bad) begin
                status <= STS_BAD_PARAM;
              end else if (!hit) begin
                status <= STS_NOT_FOUND;
              end else begin
                unique case (cmd_q)
                  CMD_UNREGISTER: begin
                    slot_used[sel]  <= 1'b0;
                    slot_state[sel] <= TS_STOPPED;
                    used_count      <= used_count - 1'b1;
                    if (task_busy && (running_slot == sel)) begin
                      task_busy <= 1'b0;
                    end
                  end
                  CMD_START: begin
                    slot_state[sel] <= TS_READY;
                  end
                  CMD_STOP: begin
                    slot_state[sel] <= TS_STOPPED;
                  end
                  CMD_SUSPEND: begin
                    if (sel_state == TS_READY || sel_state == TS_RUNNING) begin
                      slot_state[sel] <= TS_SUSPENDED;
                    end else begin
                      status <= STS_BAD_STATE;
                    end
                  end
                  CMD_RESUME: begin
                    if (sel_state == TS_SUSPENDED) begin
                      slot_state[sel] <= TS_READY;
                    end else begin
                      status <= STS_BAD_STATE;
                    end
                  end
                  CMD_READ: begin
                    info_period     <= ent_q.period;
                    info_priority   <= ent_q.priority_num;
                    info_last_run   <= ent_q.last_run;
                    info_max_exec   <= ent_q.max_exec;
                    info_max_jitter <= ent_q.max_jitter;
                    info_state      <= sel_state;
                  end
                  default: begin
                    // Set period, set priority and statistics clear only touch the memory.
                  end
                endcase
              end
            end
          endcase
        end
        default: begin
          fsm <= S_IDLE;
        end
      endcase
    end
  end

  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("done strobe without a command in progress");

  a_start_takes: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted command did not raise busy");

  a_count_matches: assert property (@(posedge clk) disable iff (rst)
    !busy |-> (used_count == CNT_W'($countones(slot_used))))
    else $error("task count disagrees with occupied slots");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    used_count <= CNT_W'(TASKS))
    else $error("task count above table size");

endmodule

### dv/periodic_priority_task_scheduler_test.sv
// ----------------------------------------------------------------------------
// Periodic priority task scheduler testbench
// Drives scheduler commands through the start/busy handshake and programs the
// priority limit over APB. Each command result is predicted from a
// behavioural copy of the task table and compared field by field with the
// done strobe output.
// ----------------------------------------------------------------------------
module periodic_priority_task_scheduler_test;
  timeunit 1ns;
  timeprecision 1ps;
  import pts_pkg::*;

  typedef struct packed {
    logic [2:0]  status;
    logic [7:0]  result_id;
    logic        found;
    logic [31:0] info_period;
    logic [7:0]  info_priority;
    logic [31:0] info_last_run;
    logic [31:0] info_max_exec;
    logic [31:0] info_max_jitter;
    logic [1:0]  info_state;
    logic [4:0]  task_count;
    logic [4:0]  affected_count;
  } cmd_result_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        start;
  logic        busy;
  logic [3:0]  command;
  logic [31:0] now;
  logic [7:0]  task_id;
  logic [31:0] period;
  logic [7:0]  priority_req;
  logic        done;
  logic [2:0]  status;
  logic [7:0]  result_id;
  logic        found;
  logic [31:0] info_period;
  logic [7:0]  info_priority;
  logic [31:0] info_last_run;
  logic [31:0] info_max_exec;
  logic [31:0] info_max_jitter;
  logic [1:0]  info_state;
  logic [CNT_W-1:0] task_count;
  logic [CNT_W-1:0] affected_count;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  periodic_priority_task_scheduler uut (.*);

  always #4 clk = ~clk;

  // Shadow copy of the task table.
  logic        tbl_used   [TASKS];
  logic [1:0]  tbl_state  [TASKS];
  logic [7:0]  tbl_tag    [TASKS];
  logic [31:0] tbl_period [TASKS];
  logic [7:0]  tbl_prio   [TASKS];
  logic [31:0] tbl_last   [TASKS];
  logic [31:0] tbl_exec   [TASKS];
  logic [31:0] tbl_jitter [TASKS];
  logic [7:0]  tag_next;
  logic [4:0]  tasks_held;
  logic        task_busy;
  int          busy_slot;
  logic [7:0]  prio_limit;

  cmd_result_t results_due[$];
  int          errors = 0;
  int          idle_pct = 0;
  logic [31:0] tick = 0;

  function automatic int slot_of(logic [7:0] id);
    for (int i = 0; i < TASKS; i++)
      if (tbl_used[i] && tbl_tag[i] == id) return i;
    return -1;
  endfunction

  function automatic logic slot_due(int i, logic [31:0] t);
    logic [31:0] elapsed;
    elapsed = t - tbl_last[i];
    return tbl_used[i] && tbl_state[i] == TS_READY && elapsed >= tbl_period[i];
  endfunction

  function automatic void wipe_slot(int i);
    tbl_used[i] = 1'b0; tbl_state[i] = TS_STOPPED; tbl_tag[i] = '0;
    tbl_period[i] = '0; tbl_prio[i] = '0; tbl_last[i] = '0;
    tbl_exec[i] = '0; tbl_jitter[i] = '0;
  endfunction

  function automatic cmd_result_t schedule_step(logic [3:0] cmd, logic [31:0] t,
                                                logic [7:0] id, logic [31:0] per,
                                                logic [7:0] pri);
    cmd_result_t r;
    int s;
    logic [7:0] best;
    logic [31:0] sched, jit, ex;
    r = '0;
    s = -1;
    case (cmd)
      CMD_REGISTER: begin
        if (tasks_held < TASKS)
          for (int i = 0; i < TASKS; i++)
            if (!tbl_used[i] && s < 0) s = i;
        if (s < 0) begin
          r.status = STS_FULL;
        end else begin
          tbl_used[s] = 1'b1; tbl_state[s] = TS_READY; tbl_period[s] = per;
          tbl_prio[s] = pri; tbl_last[s] = t; tbl_exec[s] = '0; tbl_jitter[s] = '0;
          tbl_tag[s] = tag_next;
          r.result_id = tag_next;
          tag_next++;
          tasks_held++;
        end
      end
      CMD_DISPATCH: begin
        if (task_busy) begin
          r.status = STS_BAD_STATE;
        end else begin
          best = PRIO_NONE;
          for (int i = 0; i < TASKS; i++)
            if (slot_due(i, t) && tbl_prio[i] < best) begin
              best = tbl_prio[i];
              s = i;
            end
          if (s >= 0) begin
            sched = tbl_last[s] + tbl_period[s];
            jit = (t > sched) ? t - sched : sched - t;
            if (jit > tbl_jitter[s]) tbl_jitter[s] = jit;
            tbl_last[s] = t;
            tbl_state[s] = TS_RUNNING;
            task_busy = 1'b1;
            busy_slot = s;
            r.found = 1'b1;
            r.result_id = tbl_tag[s];
          end
        end
      end
      CMD_COMPLETE: begin
        if (!task_busy) begin
          r.status = STS_BAD_STATE;
        end else begin
          ex = t - tbl_last[busy_slot];
          if (ex > tbl_exec[busy_slot]) tbl_exec[busy_slot] = ex;
          if (tbl_state[busy_slot] == TS_RUNNING) tbl_state[busy_slot] = TS_READY;
          task_busy = 1'b0;
          r.result_id = tbl_tag[busy_slot];
        end
      end
      CMD_SUSP_ALL, CMD_RES_ALL: begin
        for (int i = 0; i < TASKS; i++) begin
          if (!tbl_used[i]) continue;
          if (cmd == CMD_SUSP_ALL &&
              (tbl_state[i] == TS_READY || tbl_state[i] == TS_RUNNING)) begin
            tbl_state[i] = TS_SUSPENDED;
            r.affected_count++;
          end else if (cmd == CMD_RES_ALL && tbl_state[i] == TS_SUSPENDED) begin
            tbl_state[i] = TS_READY;
            tbl_last[i] = t;
            r.affected_count++;
          end
        end
      end
      CMD_PENDING: begin
        for (int i = 0; i < TASKS; i++)
          if (slot_due(i, t)) r.found = 1'b1;
      end
      CMD_UNREGISTER, CMD_START, CMD_STOP, CMD_SUSPEND, CMD_RESUME, CMD_SET_PERIOD,
      CMD_SET_PRIO, CMD_READ, CMD_CLR_STATS: begin
        r.result_id = id;
        s = slot_of(id);
        if ((cmd == CMD_SET_PERIOD && per == 0) || (cmd == CMD_SET_PRIO && pri > prio_limit))
          r.status = STS_BAD_PARAM;
        else if (s < 0)
          r.status = STS_NOT_FOUND;
        else
          case (cmd)
            CMD_UNREGISTER: begin
              wipe_slot(s);
              tasks_held--;
              if (task_busy && busy_slot == s) task_busy = 1'b0;
            end
            CMD_START: begin
              tbl_state[s] = TS_READY;
              tbl_last[s] = t;
            end
            CMD_STOP: tbl_state[s] = TS_STOPPED;
            CMD_SUSPEND: begin
              if (tbl_state[s] == TS_READY || tbl_state[s] == TS_RUNNING)
                tbl_state[s] = TS_SUSPENDED;
              else
                r.status = STS_BAD_STATE;
            end
            CMD_RESUME: begin
              if (tbl_state[s] == TS_SUSPENDED) begin
                tbl_state[s] = TS_READY;
                tbl_last[s] = t;
              end else begin
                r.status = STS_BAD_STATE;
              end
            end
            CMD_SET_PERIOD: begin
              tbl_period[s] = per;
              tbl_last[s] = t;
            end
            CMD_SET_PRIO: tbl_prio[s] = pri;
            CMD_READ: begin
              r.info_period = tbl_period[s]; r.info_priority = tbl_prio[s];
              r.info_last_run = tbl_last[s]; r.info_max_exec = tbl_exec[s];
              r.info_max_jitter = tbl_jitter[s]; r.info_state = tbl_state[s];
            end
            default: begin
              tbl_exec[s] = '0;
              tbl_jitter[s] = '0;
            end
          endcase
      end
      default: r.status = STS_BAD_PARAM;
    endcase
    r.task_count = tasks_held;
    return r;
  endfunction

  // Sends one command; start is left high so back-to-back commands need no
  // second assignment in the same step.
  task automatic send_cmd(logic [3:0] cmd, logic [31:0] t, logic [7:0] id,
                          logic [31:0] per, logic [7:0] pri);
    command <= cmd; now <= t; task_id <= id; period <= per; priority_req <= pri;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    results_due.push_back(schedule_step(cmd, t, id, per, pri));
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 30)) @(posedge clk);
    end
  endtask

  task automatic drain;
    start <= 1'b0;
    @(posedge clk);
    while (results_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_limit(logic [31:0] value);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= '0; pwdata <= value; penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    prio_limit = value[7:0];
  endtask

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      errors++;
    end
  endtask

  cmd_result_t want;
  always @(posedge clk) begin
    if (!rst && done) begin
      if (results_due.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual status %0d id %0d",
                 $time, status, result_id);
        errors++;
      end else begin
        want = results_due.pop_front();
        check_field("status", 32'(want.status), 32'(status));
        check_field("result_id", 32'(want.result_id), 32'(result_id));
        check_field("found", 32'(want.found), 32'(found));
        check_field("info_period", want.info_period, info_period);
        check_field("info_priority", 32'(want.info_priority), 32'(info_priority));
        check_field("info_last_run", want.info_last_run, info_last_run);
        check_field("info_max_exec", want.info_max_exec, info_max_exec);
        check_field("info_max_jitter", want.info_max_jitter, info_max_jitter);
        check_field("info_state", 32'(want.info_state), 32'(info_state));
        check_field("task_count", 32'(want.task_count), 32'(task_count));
        check_field("affected_count", 32'(want.affected_count), 32'(affected_count));
      end
    end
  end

  task automatic test_dispatch_flow;
    send_cmd(CMD_REGISTER, 32'd100, 8'd0, 32'd10, 8'd5);
    send_cmd(CMD_REGISTER, 32'd100, 8'd0, 32'd10, 8'd5);
    send_cmd(CMD_REGISTER, 32'd100, 8'd0, 32'hFFFF_FFFF, 8'd255);
    send_cmd(CMD_PENDING, 32'd105, 8'd0, 32'd0, 8'd0);
    send_cmd(CMD_DISPATCH, 32'd105, 8'd0, 32'd0, 8'd0);   // nothing due yet
    send_cmd(CMD_PENDING, 32'd112, 8'd0, 32'd0, 8'd0);
    send_cmd(CMD_DISPATCH, 32'd112, 8'd0, 32'd0, 8'd0);   // tie: lower slot wins
    send_cmd(CMD_DISPATCH, 32'd113, 8'd0, 32'd0, 8'd0);   // already busy
    send_cmd(CMD_COMPLETE, 32'd140, 8'd0, 32'd0, 8'd0);
    send_cmd(CMD_COMPLETE, 32'd141, 8'd0, 32'd0, 8'd0);   // not busy
    send_cmd(CMD_SET_PERIOD, 32'd50, 8'd1, 32'd20, 8'd0);
    send_cmd(CMD_DISPATCH, 32'd60, 8'd1, 32'd0, 8'd0);     // early: jitter below schedule
    send_cmd(CMD_UNREGISTER, 32'd61, 8'd1, 32'd0, 8'd0);   // unregister a task that is not the busy one
    send_cmd(CMD_READ, 32'd62, 8'd0, 32'd0, 8'd0);
    send_cmd(CMD_CLR_STATS, 32'd63, 8'd0, 32'd0, 8'd0);
    send_cmd(CMD_READ, 32'd64, 8'd2, 32'd0, 8'd0);
    drain();
  endtask

  task automatic test_error_cases;
    write_limit(32'hFFFF_FF0A);
    send_cmd(CMD_SET_PRIO, 32'd0, 8'd0, 32'd0, 8'd11);
    send_cmd(CMD_SET_PRIO, 32'd0, 8'd0, 32'd0, 8'd10);
    send_cmd(CMD_SET_PERIOD, 32'd0, 8'd200, 32'd0, 8'd0);
    send_cmd(CMD_START, 32'd0, 8'd200, 32'd0, 8'd0);
    send_cmd(CMD_RESUME, 32'd0, 8'd0, 32'd0, 8'd0);
    send_cmd(CMD_STOP, 32'd0, 8'd0, 32'd0, 8'd0);
    send_cmd(CMD_SUSPEND, 32'd0, 8'd0, 32'd0, 8'd0);
    send_cmd(CMD_START, 32'hFFFF_FFFF, 8'd0, 32'd0, 8'd0);
    send_cmd(CMD_SUSP_ALL, 32'd5, 8'd0, 32'd0, 8'd0);
    send_cmd(CMD_SUSPEND, 32'd5, 8'd0, 32'd0, 8'd0);
    send_cmd(CMD_RES_ALL, 32'd7, 8'd0, 32'd0, 8'd0);
    send_cmd(CMD_RESERVED, 32'd7, 8'hFF, 32'hFFFF_FFFF, 8'hFF);
    drain();
    write_limit(32'd0);
  endtask

  task automatic test_table_full;
    for (int i = 0; i < TASKS + 2; i++)
      send_cmd(CMD_REGISTER, tick, 8'd0, 32'd1 + i, 8'(i));
    send_cmd(CMD_SET_PRIO, tick, 8'd2, 32'd0, 8'd1);
    send_cmd(CMD_SET_PRIO, tick, 8'd2, 32'd0, 8'd0);
    drain();
    write_limit(32'd255);
  endtask

  function automatic logic [7:0] pick_id;
    int slots[$];
    for (int i = 0; i < TASKS; i++) if (tbl_used[i]) slots.push_back(i);
    if (slots.size() == 0 || $urandom_range(99) < 12) return 8'($urandom);
    return tbl_tag[slots[$urandom_range(slots.size() - 1)]];
  endfunction

  task automatic test_random(int count);
    int roll;
    logic [3:0] cmd;
    logic [31:0] per;
    logic [7:0] pri;
    for (int n = 0; n < count; n++) begin
      roll = $urandom_range(99);
      if ($urandom_range(99) < 3) tick = $urandom;
      else tick += $urandom_range(0, 25);
      if (roll < 12)      cmd = (tasks_held < 12 || roll < 3) ? CMD_REGISTER : CMD_UNREGISTER;
      else if (roll < 34) cmd = CMD_DISPATCH;
      else if (roll < 52) cmd = CMD_COMPLETE;
      else if (roll < 57) cmd = CMD_PENDING;
      else if (roll < 66) cmd = CMD_READ;
      else if (roll < 68) cmd = CMD_RESERVED;
      else if (roll < 71) cmd = (roll == 70) ? CMD_SUSP_ALL : CMD_RES_ALL;
      else                cmd = 4'($urandom_range(CMD_UNREGISTER, CMD_CLR_STATS));
      per = ($urandom_range(9) == 0) ? $urandom : $urandom_range(0, 60);
      pri = ($urandom_range(4) == 0) ? 8'($urandom) : 8'($urandom_range(0, 8));
      send_cmd(cmd, tick, pick_id(), per, pri);
    end
    drain();
  endtask

  initial begin
    rst <= 1'b1; start <= 1'b0; command <= '0; now <= '0; task_id <= '0;
    period <= '0; priority_req <= '0;
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0; paddr <= '0; pwdata <= '0;
    for (int i = 0; i < TASKS; i++) wipe_slot(i);
    tag_next = '0; tasks_held = '0; task_busy = 1'b0; busy_slot = 0; prio_limit = 8'd255;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_dispatch_flow();
    test_error_cases();
    test_table_full();
    test_random(350);
    idle_pct = 46;
    write_limit($urandom_range(0, 255));
    test_random(350);
    idle_pct = 0;
    write_limit(32'd4);
    test_random(350);
    idle_pct = 35;
    write_limit(32'd255);
    test_random(350);

    repeat (30) @(posedge clk);
    if (errors == 0 && results_due.size() == 0) begin
      $display("periodic_priority_task_scheduler_test: PASS");
    end else begin
      $display("periodic_priority_task_scheduler_test: FAIL");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("periodic_priority_task_scheduler_test: FAIL");
    $finish;
  end

endmodule

### sim.f
rtl/pts_pkg.sv
rtl/pts_slot_ram.sv
rtl/periodic_priority_task_scheduler.sv
dv/periodic_priority_task_scheduler_test.sv
